@@ sv/quarter_rate_dc_notch_iq_macros.svh @@
// Assertion macros for the quarter-rate DC notch.
// Used by the top level; the bodies are empty when SYNTHESIS is defined.
`ifndef QUARTER_RATE_DC_NOTCH_IQ_MACROS_SVH
`define QUARTER_RATE_DC_NOTCH_IQ_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define QRDN_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication.
`define QRDN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define QRDN_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define QRDN_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/qrdn_pkg.sv @@
// Shared types and constants for the quarter-rate DC notch.
// No dependencies; imported by every module of the block.
`default_nettype none
package qrdn_pkg;

  // Rotation phase: the sample is multiplied by j^phase.
  typedef logic [1:0] phase_t;

  localparam phase_t PH_ROT0   = 2'd0;  // x 1
  localparam phase_t PH_ROT90  = 2'd1;  // x j
  localparam phase_t PH_ROT180 = 2'd2;  // x -1
  localparam phase_t PH_ROT270 = 2'd3;  // x -j

  // Smoothing weight register
  localparam int unsigned GAIN_W = 15;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd3277;

endpackage
`default_nettype wire

@@ sv/qrdn_rotate.sv @@
// Complex rotation by j^phase, one bit of growth for the negated full-scale value.
// Depends on qrdn_pkg.
`default_nettype none
module qrdn_rotate #(
  parameter int unsigned W = 16
) (
  input  qrdn_pkg::phase_t phase_i,
  input  logic signed [W-1:0] re_i,
  input  logic signed [W-1:0] im_i,
  output logic signed [W:0]   re_o,
  output logic signed [W:0]   im_o
);
  import qrdn_pkg::*;

  logic signed [W:0] re_ext;
  logic signed [W:0] im_ext;
  logic signed [W:0] re_neg;
  logic signed [W:0] im_neg;

  assign re_ext = {re_i[W-1], re_i};
  assign im_ext = {im_i[W-1], im_i};
  assign re_neg = -re_ext;
  assign im_neg = -im_ext;

  always_comb begin
    case (phase_i)
      PH_ROT0: begin
        re_o = re_ext;
        im_o = im_ext;
      end
      PH_ROT90: begin
        re_o = im_neg;
        im_o = re_ext;
      end
      PH_ROT180: begin
        re_o = re_neg;
        im_o = im_neg;
      end
      PH_ROT270: begin
        re_o = im_ext;
        im_o = re_neg;
      end
      default: begin
        re_o = re_ext;
        im_o = im_ext;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ sv/qrdn_leak.sv @@
// One-pole leaky average update: floor((avg*(ONE-g) + x*g) / 2^(SB-1)).
// Depends on qrdn_pkg for the gain register width.
`default_nettype none
module qrdn_leak #(
  parameter int unsigned SB = 16
) (
  input  logic [qrdn_pkg::GAIN_W-1:0] gain_i,
  input  logic signed [SB-1:0]        avg_i,
  input  logic signed [SB:0]          x_i,
  output logic signed [SB-1:0]        avg_o
);
  import qrdn_pkg::*;

  localparam int unsigned QS = SB - 1;
  localparam int unsigned GW = (GAIN_W > QS) ? GAIN_W : QS;
  localparam logic [GW-1:0] ONE_G = GW'({QS{1'b1}});

  logic [GW-1:0]            gain_ext;
  logic [GW-1:0]            gain_sat;
  logic [QS-1:0]            g;
  logic [QS-1:0]            coef;
  logic signed [2*SB-1:0]   prod_avg;
  logic signed [2*SB:0]     prod_x;
  logic signed [2*SB+1:0]   acc;
  logic signed [2*SB+1:0]   acc_sh;

  // Clamp the weight to one in the sample's Q format
  assign gain_ext = GW'(gain_i);
  assign gain_sat = (gain_ext > ONE_G) ? ONE_G : gain_ext;
  assign g        = gain_sat[QS-1:0];
  assign coef     = ONE_G[QS-1:0] - g;

  assign prod_avg = avg_i * $signed({1'b0, coef});
  assign prod_x   = x_i * $signed({1'b0, g});
  assign acc      = {{2{prod_avg[2*SB-1]}}, prod_avg} + {prod_x[2*SB], prod_x};
  assign acc_sh   = acc >>> QS;
  assign avg_o    = acc_sh[SB-1:0];

endmodule
`default_nettype wire

@@ sv/quarter_rate_dc_notch_iq.sv @@
// Path: an input transaction is held in the input register, then in the result register.
// Throughput: one transaction per cycle unless m_axis_tready stalls the output; the
// leaky-average loop (two multiplies and an add) closes within the second stage, from
// the average registers back to themselves.
// Reset: phase, both averages and all valid flags clear; gain returns to 3277.
// Depends on qrdn_pkg, qrdn_rotate, qrdn_leak and the assertion macro header.
`default_nettype none
`include "quarter_rate_dc_notch_iq_macros.svh"
module quarter_rate_dc_notch_iq #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [qrdn_pkg::GAIN_W-1:0]         cfg_wdata_i,   // gain
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // sample_re, sample_im, zero pad
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // out_re, out_im, zero pad
  output logic [((2*SAMPLE_BITS+9)/8)*8-1:0]  m_axis_tdata
);
  import qrdn_pkg::*;

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned OUT_W = ((2*SAMPLE_BITS+9)/8)*8;

  logic [GAIN_W-1:0]    gain_q;
  phase_t               phase_q, phase_d;
  logic                 s1_valid_q, s1_valid_d;
  logic signed [SB:0]   s1_re_q, s1_im_q;
  phase_t               s1_phase_q;
  logic signed [SB-1:0] avg_re_q, avg_re_d;
  logic signed [SB-1:0] avg_im_q, avg_im_d;
  logic                 out_valid_q, out_valid_d;
  logic signed [SB:0]   out_re_q, out_re_d;
  logic signed [SB:0]   out_im_q, out_im_d;

  logic                 in_acc;
  logic                 out_ld;
  logic                 s1_adv;
  logic signed [SB:0]   rot_re, rot_im;
  logic signed [SB+1:0] diff_re, diff_im;
  logic signed [SB+2:0] back_re, back_im;
  phase_t               inv_phase;

  assign out_ld        = !out_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && out_ld;
  assign s_axis_tready = !s1_valid_q || out_ld;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Stage one: rotate by j^phase
  qrdn_rotate #(.W(SB)) u_rot_fwd (
    .phase_i (phase_q),
    .re_i    (s_axis_tdata[SB-1:0]),
    .im_i    (s_axis_tdata[2*SB-1:SB]),
    .re_o    (rot_re),
    .im_o    (rot_im)
  );

  // Stage two: update averages, subtract, rotate back
  qrdn_leak #(.SB(SB)) u_leak_re (
    .gain_i (gain_q),
    .avg_i  (avg_re_q),
    .x_i    (s1_re_q),
    .avg_o  (avg_re_d)
  );

  qrdn_leak #(.SB(SB)) u_leak_im (
    .gain_i (gain_q),
    .avg_i  (avg_im_q),
    .x_i    (s1_im_q),
    .avg_o  (avg_im_d)
  );

  assign diff_re   = {s1_re_q[SB], s1_re_q} - {{2{avg_re_d[SB-1]}}, avg_re_d};
  assign diff_im   = {s1_im_q[SB], s1_im_q} - {{2{avg_im_d[SB-1]}}, avg_im_d};
  assign inv_phase = PH_ROT0 - s1_phase_q;

  qrdn_rotate #(.W(SB+2)) u_rot_inv (
    .phase_i (inv_phase),
    .re_i    (diff_re),
    .im_i    (diff_im),
    .re_o    (back_re),
    .im_o    (back_im)
  );

  // Result wraps to SB+1 bits; the true value always fits
  assign out_re_d    = back_re[SB:0];
  assign out_im_d    = back_im[SB:0];
  assign phase_d     = phase_q + 2'd1;
  assign s1_valid_d  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = out_ld ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= GAIN_RESET;
      phase_q     <= PH_ROT0;
      s1_valid_q  <= 1'b0;
      avg_re_q    <= '0;
      avg_im_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        gain_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        phase_q <= phase_d;
      end
      // Averages advance only when an item leaves stage one
      if (s1_adv) begin
        avg_re_q <= avg_re_d;
        avg_im_q <= avg_im_d;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_re_q    <= rot_re;
      s1_im_q    <= rot_im;
      s1_phase_q <= phase_q;
    end
    if (s1_adv) begin
      out_re_q <= out_re_d;
      out_im_q <= out_im_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({out_im_q, out_re_q});

  `QRDN_ASSERT_NEXT(a_phase_step, clk_i, rst_ni, in_acc, phase_q == 2'($past(phase_q) + 2'd1))
  `QRDN_ASSERT_NEXT(a_avg_hold, clk_i, rst_ni, !s1_adv, $stable(avg_re_q) && $stable(avg_im_q))
  `QRDN_ASSERT_IMPL(a_full_stall, clk_i, rst_ni, s1_valid_q && out_valid_q && !m_axis_tready, !s_axis_tready)
  `QRDN_ASSERT_NEXT(a_out_fill, clk_i, rst_ni, s1_adv, out_valid_q)

endmodule
`default_nettype wire
